// ----- src/be8n_pkg.sv -----
// Shared types and constants for the 8-neighbour binary edge block.
// Used by the interfaces, the position tracker and the top level.
package be8n_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int PIX_W       = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_VALUE   = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam int               DIM_RESET  = 1024;
    localparam logic [PIX_W-1:0] EDGE_RESET = 8'd255;

    // one window column: [2] row above, [1] center row, [0] row below
    typedef logic [2:0] t_col;

    typedef struct packed {
        logic step;
        logic emit;
        logic pix;
        logic top;
        logic bot;
        logic left;
        logic right;
        logic last;
    } t_step_ctl;

endpackage

// ----- src/be8n_in_if.sv -----
// Input channel: pixel or flush request with valid/ready handshake.
// Depends on be8n_pkg for the pixel width.
interface be8n_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [be8n_pkg::PIX_W-1:0]   pixel_value;

    modport source (output valid, output command, output pixel_value, input ready);
    modport sink   (input valid, input command, input pixel_value, output ready);
endinterface

// ----- src/be8n_out_if.sv -----
// Output channel: edge result with frame end marker, valid/ready handshake.
// Depends on be8n_pkg for the pixel width.
interface be8n_out_if;
    logic                         valid;
    logic                         ready;
    logic [be8n_pkg::PIX_W-1:0]   edge_out;
    logic                         frame_last;

    modport source (output valid, output edge_out, output frame_last, input ready);
    modport sink   (input valid, input edge_out, input frame_last, output ready);
endinterface

// ----- src/be8n_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module be8n_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- src/be8n_cell.sv -----
// One column cell of the 3x3 window chain; loads its neighbor's column.
// Depends on be8n_pkg for the column type.
module be8n_cell (
    input  logic           i_clk,
    input  logic           i_load,
    input  be8n_pkg::t_col i_col,
    output be8n_pkg::t_col o_col
);
    import be8n_pkg::*;

    t_col r_col;
    t_col n_col;

    assign n_col = i_load ? i_col : r_col;

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
    end

    assign o_col = r_col;
endmodule

// ----- src/be8n_pos.sv -----
// Frame geometry registers and raster position tracking for input and result.
// Decides per request whether it is a step, whether it emits, and the border masks.
// Depends on be8n_pkg.
module be8n_pos #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [be8n_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [be8n_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_accept,
    input  logic                                i_command,
    input  logic                                i_pix,
    output be8n_pkg::t_step_ctl                 o_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_col
);
    import be8n_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int RST_W = (DIM_RESET > MAX_WIDTH)  ? MAX_WIDTH  : DIM_RESET;
    localparam int RST_H = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

    function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
        int unsigned res;
        res = 32'(v);
        if (res < 2) begin
            res = 2;
        end else if (res > maxv) begin
            res = maxv;
        end
        return res;
    endfunction

    logic [COL_W-1:0] r_wm1, n_wm1;
    logic [ROW_W-1:0] r_hm1, n_hm1;
    logic [COL_W-1:0] r_in_col, n_in_col;
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic             r_in_done, n_in_done;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;

    logic primed;
    logic pix_step;
    logic flush_step;
    logic out_col_end;
    logic out_row_end;

    assign primed      = (r_in_row != '0) && !((r_in_row == ROW_W'(1)) && (r_in_col == '0));
    assign pix_step    = (i_command == CMD_PIXEL) && !r_in_done;
    assign flush_step  = (i_command == CMD_FLUSH) && r_in_done;
    assign out_col_end = (r_out_col == r_wm1);
    assign out_row_end = (r_out_row == r_hm1);

    always_comb begin
        o_ctl.step  = pix_step || flush_step;
        o_ctl.emit  = flush_step || (pix_step && primed);
        o_ctl.pix   = (i_command == CMD_FLUSH) || i_pix;
        o_ctl.top   = (r_out_row == '0);
        o_ctl.bot   = out_row_end;
        o_ctl.left  = (r_out_col == '0);
        o_ctl.right = out_col_end;
        o_ctl.last  = out_row_end && out_col_end;
    end

    assign o_col = r_in_col;

    always_comb begin
        n_wm1     = r_wm1;
        n_hm1     = r_hm1;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_done = r_in_done;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    n_wm1     = COL_W'(clamp_dim(i_cfg_data, MAX_WIDTH) - 1);
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_in_done = 1'b0;
                    n_out_col = '0;
                    n_out_row = '0;
                end
                REG_IMAGE_HEIGHT: begin
                    n_hm1     = ROW_W'(clamp_dim(i_cfg_data, MAX_HEIGHT) - 1);
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_in_done = 1'b0;
                    n_out_col = '0;
                    n_out_row = '0;
                end
                default: begin
                end
            endcase
        end else if (i_accept && o_ctl.step) begin
            if (r_in_col == r_wm1) begin
                n_in_col = '0;
                if (pix_step) begin
                    if (r_in_row == r_hm1) begin
                        n_in_done = 1'b1;
                    end else begin
                        n_in_row = r_in_row + ROW_W'(1);
                    end
                end
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (o_ctl.emit) begin
                if (out_col_end) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
                if (o_ctl.last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_in_done = 1'b0;
                    n_out_col = '0;
                    n_out_row = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1     <= COL_W'(RST_W - 1);
            r_hm1     <= ROW_W'(RST_H - 1);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_done <= 1'b0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_wm1     <= n_wm1;
            r_hm1     <= n_hm1;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_in_done <= n_in_done;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end
endmodule

// ----- src/binary_edge_8_neighbour.sv -----
// Inner boundary of a binary raster image over a 3x3 window of three chained column cells.
// Takes one request per cycle while the output is not stalled; a result is registered after
// the request that causes it passes the line buffer read, the window shift and the output register.
// Reset clears positions and handshake state, sets width and height to 1024 and the edge
// value to 255; line buffer contents are not cleared, border masks hide stale rows.
// Depends on be8n_pkg, be8n_in_if, be8n_out_if, be8n_pos, be8n_ram and be8n_cell.
module binary_edge_8_neighbour #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [be8n_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [be8n_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    be8n_in_if.sink                             i_in,
    be8n_out_if.source                          o_out
);
    import be8n_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [PIX_W-1:0] r_edge_value;

    t_step_ctl        ctl;
    logic [COL_W-1:0] col;
    logic             accept;
    logic             step_in;

    logic             r_a_valid, n_a_valid;
    t_step_ctl        r_a_ctl;
    logic [COL_W-1:0] r_a_col;
    logic [1:0]       rd_data;

    logic             r_b_pend, n_b_pend;
    t_step_ctl        r_b_ctl;

    logic             r_o_valid, n_o_valid;
    logic [PIX_W-1:0] r_o_edge;
    logic             r_o_last;

    logic out_free;
    logic b_move;
    logic b_free;
    logic a_move;
    logic a_free;

    t_col new_col;
    t_col win0, win1, win2;
    t_col msk0, msk1, msk2;
    t_col row_mask;
    logic is_edge;

    assign out_free = !r_o_valid || o_out.ready;
    assign b_move   = r_b_pend && out_free;
    assign b_free   = !r_b_pend || out_free;
    assign a_move   = r_a_valid && b_free;
    assign a_free   = !r_a_valid || a_move;

    assign i_in.ready = a_free;
    assign accept     = i_in.valid && a_free;
    assign step_in    = accept && ctl.step;

    be8n_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_command   (i_in.command),
        .i_pix       (|i_in.pixel_value),
        .o_ctl       (ctl),
        .o_col       (col)
    );

    // line buffer entry per column: [1] previous row, [0] row before that
    be8n_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (a_move),
        .i_wr_addr (r_a_col),
        .i_wr_data ({r_a_ctl.pix, rd_data[1]}),
        .i_rd_en   (step_in),
        .i_rd_addr (col),
        .o_rd_data (rd_data)
    );

    assign new_col = {rd_data[0], rd_data[1], r_a_ctl.pix};

    be8n_cell u_cell2 (.i_clk(i_clk), .i_load(a_move), .i_col(new_col), .o_col(win2));
    be8n_cell u_cell1 (.i_clk(i_clk), .i_load(a_move), .i_col(win2),    .o_col(win1));
    be8n_cell u_cell0 (.i_clk(i_clk), .i_load(a_move), .i_col(win1),    .o_col(win0));

    // force neighbors outside the frame to foreground
    assign row_mask = {r_b_ctl.top, 1'b0, r_b_ctl.bot};
    assign msk0     = win0 | row_mask | {3{r_b_ctl.left}};
    assign msk1     = win1 | row_mask;
    assign msk2     = win2 | row_mask | {3{r_b_ctl.right}};
    assign is_edge  = win1[1] && !(&{msk0, msk1, msk2});

    always_comb begin
        n_a_valid = r_a_valid;
        if (step_in) begin
            n_a_valid = 1'b1;
        end else if (a_move) begin
            n_a_valid = 1'b0;
        end

        n_b_pend = r_b_pend;
        if (a_move) begin
            n_b_pend = r_a_ctl.emit;
        end else if (b_move) begin
            n_b_pend = 1'b0;
        end

        n_o_valid = r_o_valid;
        if (b_move) begin
            n_o_valid = 1'b1;
        end else if (o_out.ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_value <= EDGE_RESET;
            r_a_valid    <= 1'b0;
            r_b_pend     <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == REG_EDGE_VALUE)) begin
                r_edge_value <= i_cfg_data[PIX_W-1:0];
            end
            r_a_valid <= n_a_valid;
            r_b_pend  <= n_b_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_in) begin
            r_a_ctl <= ctl;
            r_a_col <= col;
        end
        if (a_move) begin
            r_b_ctl <= r_a_ctl;
        end
        if (b_move) begin
            r_o_edge <= is_edge ? r_edge_value : '0;
            r_o_last <= r_b_ctl.last;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.edge_out   = r_o_edge;
    assign o_out.frame_last = r_o_last;
endmodule
